FILE: sv/rom_bank_lru_slot_cache_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ROM bank slot cache
// Shared forms for concurrent checks, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ROM_BANK_LRU_SLOT_CACHE_CORE_MACROS_SVH
`define ROM_BANK_LRU_SLOT_CACHE_CORE_MACROS_SVH

// Same-cycle implication.
`define RBLSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RBLSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rblsc_pkg.sv
// ----------------------------------------------------------------------------
// rblsc_pkg
// Constants, codes and shared types of the ROM bank slot cache.
// ----------------------------------------------------------------------------
package rblsc_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int BANK_BYTES = 16384;
  localparam int PAGE_LIMIT = 512;

  localparam int ADDR_W    = 23;
  localparam int ROMSZ_W   = 24;
  localparam int SLOTS_W   = 4;
  localparam int CFG_IDX_W = 4;
  localparam int OFFSET_W  = $clog2(BANK_BYTES);
  localparam int PAGE_W    = 9;
  localparam int SLOT_W    = 3;
  localparam int STAMP_W   = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BYTES    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    KIND_OUTSIDE = 2'd0,
    KIND_FIXED   = 2'd1,
    KIND_HIT     = 2'd2,
    KIND_MISS    = 2'd3
  } access_kind_e;

  // One classified transaction waiting for the back end.
  typedef struct packed {
    logic                lookup;
    access_kind_e        kind;
    logic [OFFSET_W-1:0] offset;
    logic [PAGE_W-1:0]   page;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: sv/rblsc_front.sv
// ----------------------------------------------------------------------------
// rblsc_front
// Holds the configuration and classifies each accepted address.
// ----------------------------------------------------------------------------
module rblsc_front import rblsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [ADDR_W-1:0]    address_i,
  input  logic                 q_full_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ROMSZ_W-1:0]   cfg_data_i,
  output logic                 cfg_ready_o,
  output logic                 push_o,
  output q_item_t              item_o,
  output logic [SLOTS_W-1:0]   slots_in_use_o
);

  logic [ROMSZ_W-1:0] rom_bytes_q;
  logic [SLOTS_W-1:0] slots_q;
  logic [PAGE_W-1:0]  page;

  assign cfg_ready_o    = 1'b1;
  assign push_o         = start_i && !q_full_i;
  assign slots_in_use_o = slots_q;
  assign page           = address_i[ADDR_W-1:OFFSET_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_bytes_q <= '0;
      slots_q     <= SLOTS_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROM_BYTES:    rom_bytes_q <= cfg_data_i;
        CFG_SLOTS_IN_USE: slots_q     <= cfg_data_i[SLOTS_W-1:0];
        default: ;
      endcase
    end
  end

  // Resolve what the address and configuration decide; mark switchable pages for lookup.
  always_comb begin
    item_o = '{lookup: 1'b0, kind: KIND_OUTSIDE, offset: '0, page: '0};
    if ({1'b0, address_i} >= rom_bytes_q) begin
      item_o.kind = KIND_OUTSIDE;
    end else if (address_i < ADDR_W'(BANK_BYTES)) begin
      item_o.kind   = KIND_FIXED;
      item_o.offset = address_i[OFFSET_W-1:0];
    end else if (rom_bytes_q <= ROMSZ_W'(2 * BANK_BYTES)) begin
      item_o.kind   = KIND_HIT;
      item_o.offset = address_i[OFFSET_W-1:0];
    end else if ({1'b0, page} >= (PAGE_W + 1)'(PAGE_LIMIT)) begin
      item_o.kind = KIND_OUTSIDE;
    end else begin
      item_o.lookup = 1'b1;
      item_o.kind   = KIND_HIT;
      item_o.offset = address_i[OFFSET_W-1:0];
      item_o.page   = page;
    end
  end

endmodule

FILE: sv/rblsc_queue.sv
// ----------------------------------------------------------------------------
// rblsc_queue
// Short FIFO that decouples classification from the slot lookup.
// ----------------------------------------------------------------------------
module rblsc_queue import rblsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  q_item_t   item_i,
  input  logic      pop_i,
  output q_item_t   head_o,
  output q_status_t status_o
);

  q_item_t           entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_o         = entry_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= item_i;
  end

endmodule

FILE: sv/rblsc_back.sv
// ----------------------------------------------------------------------------
// rblsc_back
// Slot lookup with least-recently-used replacement, one slot per cycle.
// ----------------------------------------------------------------------------
module rblsc_back import rblsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  q_item_t             head_i,
  input  logic [SLOTS_W-1:0]  slots_in_use_i,
  output logic                pop_o,
  output logic                scanning_o,
  output logic                result_valid_o,
  output access_kind_e        access_kind_o,
  output logic [SLOT_W-1:0]   slot_o,
  output logic [OFFSET_W-1:0] offset_o,
  output logic [PAGE_W-1:0]   fill_page_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                state_q, state_d;
  logic [SLOT_W-1:0]   idx_q, idx_d, victim_q, victim_d;
  logic [STAMP_W-1:0]  best_q, best_d;
  logic [PAGE_W-1:0]   page_q, page_d;
  logic [OFFSET_W-1:0] off_q, off_d;

  logic [PAGE_W-1:0]    tag_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_q;
  logic [STAMP_W-1:0]   stamp_q [SLOT_COUNT];
  logic [STAMP_W-1:0]   cnt_q, cnt_d, new_stamp;
  logic [PAGE_W-1:0]    cur_page_q, cur_page_d;
  logic                 cur_valid_q, cur_valid_d;
  logic [SLOT_W-1:0]    cur_slot_q, cur_slot_d;

  logic                res_valid_q, res_valid_d;
  access_kind_e        res_kind_q, res_kind_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic [OFFSET_W-1:0] res_off_q, res_off_d;
  logic [PAGE_W-1:0]   res_page_q, res_page_d;

  logic [SLOTS_W-1:0] n_lim;
  logic [SLOT_W-1:0]  last_idx, upd_slot;
  logic               hit_now, lower, upd_en, upd_miss;

  // Clamp the slot count to one through SLOT_COUNT.
  always_comb begin
    if (slots_in_use_i == '0) begin
      n_lim = SLOTS_W'(1);
    end else if (slots_in_use_i > SLOTS_W'(SLOT_COUNT)) begin
      n_lim = SLOTS_W'(SLOT_COUNT);
    end else begin
      n_lim = slots_in_use_i;
    end
  end

  assign last_idx  = SLOT_W'(n_lim - 1'b1);
  assign hit_now   = valid_q[idx_q] && (tag_q[idx_q] == page_q);
  assign lower     = (stamp_q[idx_q] < best_q);
  assign new_stamp = cnt_q + 1'b1;

  assign scanning_o     = (state_q == ST_SCAN);
  assign result_valid_o = res_valid_q;
  assign access_kind_o  = res_kind_q;
  assign slot_o         = res_slot_q;
  assign offset_o       = res_off_q;
  assign fill_page_o    = res_page_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    victim_d    = victim_q;
    best_d      = best_q;
    page_d      = page_q;
    off_d       = off_q;
    cnt_d       = cnt_q;
    cur_page_d  = cur_page_q;
    cur_valid_d = cur_valid_q;
    cur_slot_d  = cur_slot_q;
    res_valid_d = 1'b0;
    res_kind_d  = res_kind_q;
    res_slot_d  = res_slot_q;
    res_off_d   = res_off_q;
    res_page_d  = res_page_q;
    pop_o       = 1'b0;
    upd_en      = 1'b0;
    upd_miss    = 1'b0;
    upd_slot    = victim_q;

    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          if (!head_i.lookup) begin
            res_valid_d = 1'b1;
            res_kind_d  = head_i.kind;
            res_slot_d  = '0;
            res_off_d   = head_i.offset;
            res_page_d  = '0;
          end else if (cur_valid_q && (head_i.page == cur_page_q)) begin
            res_valid_d = 1'b1;
            res_kind_d  = KIND_HIT;
            res_slot_d  = cur_slot_q;
            res_off_d   = head_i.offset;
            res_page_d  = '0;
          end else begin
            state_d  = ST_SCAN;
            idx_d    = '0;
            victim_d = '0;
            best_d   = '1;
            page_d   = head_i.page;
            off_d    = head_i.offset;
          end
        end
      end
      ST_SCAN: begin
        if (hit_now || (idx_q == last_idx)) begin
          upd_en      = 1'b1;
          upd_miss    = !hit_now;
          upd_slot    = (hit_now || lower) ? idx_q : victim_q;
          cnt_d       = new_stamp;
          cur_slot_d  = upd_slot;
          cur_page_d  = page_q;
          cur_valid_d = 1'b1;
          res_valid_d = 1'b1;
          res_kind_d  = hit_now ? KIND_HIT : KIND_MISS;
          res_slot_d  = upd_slot;
          res_off_d   = off_q;
          res_page_d  = hit_now ? '0 : page_q;
          state_d     = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
          if (lower) begin
            victim_d = idx_q;
            best_d   = stamp_q[idx_q];
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cur_page_q  <= '0;
      cur_valid_q <= 1'b0;
      cur_slot_q  <= '0;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        stamp_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_page_q  <= cur_page_d;
      cur_valid_q <= cur_valid_d;
      cur_slot_q  <= cur_slot_d;
      res_valid_q <= res_valid_d;
      if (upd_en) begin
        stamp_q[upd_slot] <= new_stamp;
        if (upd_miss) valid_q[upd_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    victim_q   <= victim_d;
    best_q     <= best_d;
    page_q     <= page_d;
    off_q      <= off_d;
    res_kind_q <= res_kind_d;
    res_slot_q <= res_slot_d;
    res_off_q  <= res_off_d;
    res_page_q <= res_page_d;
    if (upd_en && upd_miss) tag_q[upd_slot] <= page_q;
  end

endmodule

FILE: sv/rom_bank_lru_slot_cache_core.sv
// ----------------------------------------------------------------------------
// rom_bank_lru_slot_cache_core
// Path: the front end pushes each accepted address into the queue, the back
//   end pops it and writes the result register; a bank switch adds a scan of
//   the slots, one slot per cycle, up to the slot count clamped to one through
//   eight.
// Throughput: one transaction a cycle for settled ones while no scan runs; a
//   switch holds the lookup unit while scanning; a full two-entry queue raises busy.
// Reset: rst_ni low clears configuration (rom_bytes 0, slots_in_use 1), slot
//   valid marks, use stamps, use counter and current page at once; slot tags
//   stay unset and need no clearing pass. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`include "rom_bank_lru_slot_cache_core_macros.svh"

module rom_bank_lru_slot_cache_core import rblsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command channel
  input  logic                 start,
  output logic                 busy,
  input  logic [ADDR_W-1:0]    address_i,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ROMSZ_W-1:0]   cfg_data_i,
  // result channel, one strobe per transaction
  output logic                 result_valid_o,
  output logic [1:0]           access_kind_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic [OFFSET_W-1:0]  offset_o,
  output logic [PAGE_W-1:0]    fill_page_o
);

  // The front end decides everything the address and configuration settle:
  // outside the image, fixed bank 0, the small-ROM window, and out-of-range
  // pages. Only switchable pages of a large ROM need the slot state.
  logic               push;
  q_item_t            front_item, head_item;
  q_status_t          q_status;
  logic               pop;
  logic               scanning;
  logic [SLOTS_W-1:0] slots_in_use;
  access_kind_e       kind;
  logic               res_non_miss, res_outside, res_zero, back_idle;

  // Hold off new commands only while the queue is full.
  assign busy          = q_status.full;
  assign access_kind_o = kind;

  rblsc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .address_i      (address_i),
    .q_full_i       (q_status.full),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_ready_o    (cfg_ready_o),
    .push_o         (push),
    .item_o         (front_item),
    .slots_in_use_o (slots_in_use)
  );

  // Queue classified transactions so the front keeps accepting while the
  // back end walks the slots.
  rblsc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .head_o   (head_item),
    .status_o (q_status)
  );

  // The back end pops one transaction at a time. A settled one or a hit on
  // the current page goes straight to the result register. Otherwise it
  // scans slots in index order: stop on a valid tag match, else track the
  // lowest stamp (lowest index on ties) and replace that slot. Either way the
  // use counter advances and the chosen slot takes the new stamp.
  rblsc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_status.empty),
    .head_i         (head_item),
    .slots_in_use_i (slots_in_use),
    .pop_o          (pop),
    .scanning_o     (scanning),
    .result_valid_o (result_valid_o),
    .access_kind_o  (kind),
    .slot_o         (slot_o),
    .offset_o       (offset_o),
    .fill_page_o    (fill_page_o)
  );

  assign res_non_miss = result_valid_o && (kind != KIND_MISS);
  assign res_outside  = result_valid_o && (kind == KIND_OUTSIDE);
  assign res_zero     = (slot_o == '0) && (offset_o == '0);
  assign back_idle    = !scanning && q_status.empty;

  // A fill page is named only on a miss.
  `RBLSC_ASSERT_NOW(a_fill_only_on_miss, res_non_miss, fill_page_o == '0, "fill page on a non-miss")

  // Reads outside the image carry no slot and no offset.
  `RBLSC_ASSERT_NOW(a_outside_zero, res_outside, res_zero, "outside result carries data")

  // Every strobe follows a queued transaction or a finishing slot scan.
  `RBLSC_ASSERT_NEXT(a_no_invented_result, back_idle, !result_valid_o, "strobe with nothing pending")

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: ROM bank slot cache testbench
// Drives ROM byte addresses through the command channel, predicts the
// classification, slot choice and fill page of every transaction with an
// in-bench LRU model, and compares each result strobe against it in order.
// ----------------------------------------------------------------------------
module tb_top import rblsc_pkg::*; ();

  // Any index past the register list; the block must drop such writes.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;
  // Worst case drain: two queued switches, each scanning every slot.
  localparam int SETTLE_CYCLES = 32;

  // Expected fields of one classified fetch.
  typedef struct packed {
    access_kind_e        kind;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] offset;
    logic [PAGE_W-1:0]   page;
  } bank_access_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [ADDR_W-1:0]    address_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [ROMSZ_W-1:0]   cfg_data_i;
  logic                 result_valid_o;
  logic [1:0]           access_kind_o;
  logic [SLOT_W-1:0]    slot_o;
  logic [OFFSET_W-1:0]  offset_o;
  logic [PAGE_W-1:0]    fill_page_o;

  // Predicted fetches still waiting for their result strobe, oldest first.
  bank_access_t expected_accesses[$];
  bank_access_t oldest;
  int           failures = 0;

  // Shadow of the cache: bank tags, load marks, use stamps and current page.
  logic [PAGE_W-1:0]  bank_tag    [SLOT_COUNT];
  logic               bank_loaded [SLOT_COUNT];
  logic [STAMP_W-1:0] bank_stamp  [SLOT_COUNT];
  logic [STAMP_W-1:0] use_clock;
  logic [PAGE_W-1:0]  live_page;
  logic               live_valid;
  logic [SLOT_W-1:0]  live_slot;
  logic [ROMSZ_W-1:0] rom_size;
  logic [SLOTS_W-1:0] slot_limit;

  rom_bank_lru_slot_cache_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .address_i      (address_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .access_kind_o  (access_kind_o),
    .slot_o         (slot_o),
    .offset_o       (offset_o),
    .fill_page_o    (fill_page_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Classify one accepted address and advance the shadow cache with it.
  function automatic bank_access_t predict_access(input logic [ADDR_W-1:0] addr);
    bank_access_t      r;
    int unsigned       page_full;
    logic [PAGE_W-1:0] pg;
    int                n;
    int                victim;
    bit                found;
    r = '{kind: KIND_OUTSIDE, slot: '0, offset: '0, page: '0};
    if (addr >= rom_size) return r;
    if (addr < BANK_BYTES) begin
      r.kind   = KIND_FIXED;
      r.offset = addr[OFFSET_W-1:0];
      return r;
    end
    // Two banks or fewer: the switchable bank always lives in slot 0.
    if (rom_size <= 2 * BANK_BYTES) begin
      r.kind   = KIND_HIT;
      r.offset = OFFSET_W'(addr - BANK_BYTES);
      return r;
    end
    page_full = addr / BANK_BYTES;
    if (page_full >= PAGE_LIMIT) return r;
    pg       = PAGE_W'(page_full);
    r.offset = addr[OFFSET_W-1:0];
    // Current page: report its slot, touch no stamp.
    if (live_valid && pg == live_page) begin
      r.kind = KIND_HIT;
      r.slot = live_slot;
      return r;
    end
    n = int'(slot_limit);
    if (n < 1) n = 1;
    if (n > SLOT_COUNT) n = SLOT_COUNT;
    victim = 0;
    found  = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (bank_loaded[i] && bank_tag[i] == pg) begin
        victim = i;
        found  = 1'b1;
        break;
      end
      if (bank_stamp[i] < bank_stamp[victim]) victim = i;
    end
    if (!found) begin
      bank_tag[victim]    = pg;
      bank_loaded[victim] = 1'b1;
    end
    use_clock          = use_clock + 1'b1;
    bank_stamp[victim] = use_clock;
    live_slot          = SLOT_W'(victim);
    live_page          = pg;
    live_valid         = 1'b1;
    r.slot = SLOT_W'(victim);
    if (found) begin
      r.kind = KIND_HIT;
    end else begin
      r.kind = KIND_MISS;
      r.page = pg;
    end
    return r;
  endfunction

  // Offer one address, hold it until accepted, then record its prediction.
  // Leave start high so the next transaction can follow back to back.
  task automatic send_address(input logic [ADDR_W-1:0] addr);
    start     <= 1'b1;
    address_i <= addr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_accesses.push_back(predict_access(addr));
  endtask

  // Idle the sender for a random number of cycles, idle_pct percent per cycle.
  task automatic sender_gap(input int idle_pct);
    int n;
    n = 0;
    while ($urandom_range(99) < idle_pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Stop sending and hold off until every predicted result is back,
  // then let a possible late or spurious strobe show up.
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_accesses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; valid stays high for a following write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [ROMSZ_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_ROM_BYTES:    rom_size   = value;
      CFG_SLOTS_IN_USE: slot_limit = value[SLOTS_W-1:0];
      default: ;
    endcase
  endtask

  // Drain, then load ROM size and slot count as one configuration burst.
  task automatic configure(input logic [ROMSZ_W-1:0] rom, input logic [SLOTS_W-1:0] slots);
    wait_drained();
    write_register(CFG_ROM_BYTES, rom);
    write_register(CFG_SLOTS_IN_USE, ROMSZ_W'(slots));
    cfg_valid_i <= 1'b0;
  endtask

  // Packs a page number and offset into one ROM address.
  function automatic logic [ADDR_W-1:0] page_addr(input int pg, input int off);
    return {PAGE_W'(pg), OFFSET_W'(off)};
  endfunction

  // Reset defaults: an empty image, so every read lands outside the ROM.
  task automatic test_reset_defaults();
    send_address(page_addr(1, 0));
    send_address('0);
  endtask

  // Written empty image, then a full 8 MB image with bank 0 and the top page.
  task automatic test_bounds();
    configure('0, 4'd8);
    send_address('1);
    configure(ROMSZ_W'(32'h80_0000), 4'd8);
    send_address('0);
    send_address(page_addr(0, BANK_BYTES - 1));
    send_address('1);
    send_address(page_addr(511, 0));
  endtask

  // Images of two banks or less, and one byte past two banks.
  task automatic test_small_rom();
    configure(ROMSZ_W'(2 * BANK_BYTES), 4'd8);
    send_address(page_addr(1, 0));
    send_address(page_addr(1, BANK_BYTES - 1));
    send_address(page_addr(2, 0));
    configure(ROMSZ_W'(2 * BANK_BYTES + 1), 4'd8);
    send_address(page_addr(2, 0));
    send_address(page_addr(2, 1));
  endtask

  // Two slots: refresh slot 0, reread the current page, then evict slot 1.
  task automatic test_lru_replacement();
    configure(ROMSZ_W'(32'h80_0000), 4'd2);
    send_address(page_addr(5, 3));
    send_address(page_addr(6, 4));
    send_address(page_addr(5, 5));
    send_address(page_addr(5, 6));
    send_address(page_addr(7, 7));
    send_address(page_addr(6, 8));
  endtask

  // Slot count zero behaves as one; a count above the slot array saturates.
  task automatic test_slot_count_limits();
    configure(ROMSZ_W'(32'h80_0000), 4'd0);
    send_address(page_addr(20, 0));
    send_address(page_addr(21, 0));
    send_address(page_addr(20, 0));
    configure(ROMSZ_W'(32'h80_0000), 4'hF);
    send_address(page_addr(30, 0));
    send_address(page_addr(31, 0));
    send_address(page_addr(21, 0));
  endtask

  // A write past the register list must change neither register nor cache.
  task automatic test_unused_index();
    wait_drained();
    write_register(CFG_UNUSED, '1);
    cfg_valid_i <= 1'b0;
    send_address(page_addr(31, 16383));
  endtask

  // Random traffic: mostly reads over a hot set of pages a little larger
  // than the slot count, with runs on one page, some bank 0 and stray reads.
  task automatic run_traffic(input logic [ROMSZ_W-1:0] rom, input logic [SLOTS_W-1:0] slots,
                             input int idle_pct, input int count);
    logic [PAGE_W-1:0] hot_pages [10];
    logic [PAGE_W-1:0] pg;
    int                top_page;
    int                hot_size;
    int                pick;
    configure(rom, slots);
    top_page = (rom > BANK_BYTES) ? int'((rom - 1) / BANK_BYTES) : 1;
    if (top_page > PAGE_LIMIT - 1) top_page = PAGE_LIMIT - 1;
    hot_size = (slots == 0) ? 3 : (slots > SLOT_COUNT) ? SLOT_COUNT + 2 : int'(slots) + 2;
    foreach (hot_pages[i]) hot_pages[i] = PAGE_W'($urandom_range(top_page, 1));
    pg = hot_pages[0];
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_address(ADDR_W'($urandom()));
      end else if (pick < 18) begin
        send_address(ADDR_W'($urandom_range(BANK_BYTES - 1)));
      end else begin
        // Rotate a fresh page into the hot set now and then.
        if (pick < 22) hot_pages[$urandom_range(hot_size - 1)] = PAGE_W'($urandom_range(top_page, 1));
        if ($urandom_range(1)) pg = hot_pages[$urandom_range(hot_size - 1)];
        send_address({pg, OFFSET_W'($urandom())});
      end
      sender_gap(idle_pct);
    end
  endtask

  task automatic test_random_traffic();
    run_traffic(ROMSZ_W'(32'h80_0000), 4'd8, 0, 250);
    run_traffic(ROMSZ_W'($urandom_range(32'h80_0000, 32'h8001)), SLOTS_W'($urandom_range(8, 1)),
                68, 250);
    run_traffic(ROMSZ_W'($urandom_range(32'h80_0000, 32'h8001)), 4'd3, 10, 200);
    run_traffic(ROMSZ_W'($urandom_range(2 * BANK_BYTES)), 4'd4, 68, 100);
    run_traffic(ROMSZ_W'($urandom_range(32'h80_0000, 32'h8001)), 4'd1, 0, 150);
    run_traffic(ROMSZ_W'(32'h80_0000), 4'hF, 10, 150);
    run_traffic(ROMSZ_W'($urandom_range(32'h80_0000, 32'h8001)), 4'd0, 68, 100);
  endtask

  // Pop the oldest prediction on every result strobe and compare each field.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_accesses.size() == 0) begin
        $error("unexpected result: access_kind %0d slot %0d offset %0d fill_page %0d",
               access_kind_o, slot_o, offset_o, fill_page_o);
        failures++;
      end else begin
        oldest = expected_accesses.pop_front();
        if (access_kind_o !== oldest.kind) begin
          $error("access_kind: expected %0d, actual %0d", oldest.kind, access_kind_o);
          failures++;
        end
        if (slot_o !== oldest.slot) begin
          $error("slot: expected %0d, actual %0d", oldest.slot, slot_o);
          failures++;
        end
        if (offset_o !== oldest.offset) begin
          $error("offset: expected %0d, actual %0d", oldest.offset, offset_o);
          failures++;
        end
        if (fill_page_o !== oldest.page) begin
          $error("fill_page: expected %0d, actual %0d", oldest.page, fill_page_o);
          failures++;
        end
      end
    end
  end

  initial begin
    // Hold every input at a known value and mirror the reset state.
    rst_ni      = 1'b0;
    start       = 1'b0;
    address_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      bank_tag[i]    = '0;
      bank_loaded[i] = 1'b0;
      bank_stamp[i]  = '0;
    end
    use_clock  = '0;
    live_page  = '0;
    live_valid = 1'b0;
    live_slot  = '0;
    rom_size   = '0;
    slot_limit = SLOTS_W'(1);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_bounds();
    test_small_rom();
    test_lru_replacement();
    test_slot_count_limits();
    test_unused_index();
    test_random_traffic();

    wait_drained();
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
